FILE: design/vgs_pkg.sv
// Shared types and constants for the voxel grid first-point subsampler.
// Holds the beat structs, register indexes and controller/datapath interface.
// No dependencies.
package vgs_pkg;

  localparam int GRID_DEF   = 64;
  localparam int COORD_W    = 32;
  localparam int FRAC_BITS  = 16;
  localparam int IDX_OUT_W  = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_AXES   = 3;
  localparam int AXIS_SEL_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Z  = 3'd5;

  // Scale of 1.0 in unsigned Q16.16.
  localparam logic [COORD_W-1:0] SCALE_RESET = 32'h0001_0000;

  // Input command codes.
  localparam logic CMD_POINT = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // Axis select codes for the shared multiplier.
  localparam logic [AXIS_SEL_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_SEL_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_SEL_W-1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic                      command;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] kept_x;
    logic signed [COORD_W-1:0] kept_y;
    logic signed [COORD_W-1:0] kept_z;
    logic [IDX_OUT_W-1:0]      cell_index;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                  load_pt;
    logic                  mul_en;
    logic                  sat_en;
    logic [AXIS_SEL_W-1:0] axis;
    logic                  index_en;
    logic                  clr_start;
    logic                  clearing;
    logic                  mark;
    logic                  emit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic occ;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: design/vgs_ram.sv
// Generic single-port RAM with registered read data.
// One address serves both the write and the read in a cycle. No dependencies.
module vgs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic [ADDR_W-1:0] addr,
  input  logic              wr_en,
  input  logic [WIDTH-1:0]  wr_data,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    rd_data <= mem[addr];
  end

endmodule

FILE: design/vgs_datapath.sv
// Datapath of the voxel grid subsampler: configuration registers, offset,
// shared multiplier, saturation, index packing, occupancy RAM and output register.
// Depends on vgs_pkg and vgs_ram.
module vgs_datapath import vgs_pkg::*; #(
  parameter int GRID = GRID_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_wdata,
  input  in_item_t             in_data,
  input  dp_cmd_t              cmd_i,
  output dp_sts_t              sts_o,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data
);

  localparam int AXIS_W = $clog2(GRID);
  localparam int CELLS  = GRID * GRID * GRID;
  localparam int CELL_W = $clog2(CELLS);
  localparam int PROD_W = 2 * COORD_W;
  localparam int WHOLE_W = PROD_W - FRAC_BITS;
  localparam logic [AXIS_W-1:0]  CELL_MAX     = AXIS_W'(GRID - 1);
  localparam logic [WHOLE_W-1:0] WHOLE_MAX    = WHOLE_W'(GRID - 1);
  localparam logic [CELL_W-1:0]  ROW_STRIDE   = CELL_W'(GRID);
  localparam logic [CELL_W-1:0]  PLANE_STRIDE = CELL_W'(GRID * GRID);
  localparam logic [CELL_W-1:0]  LAST_CELL    = CELL_W'(CELLS - 1);

  logic signed [COORD_W-1:0] origin_r [NUM_AXES];
  logic [COORD_W-1:0]        scale_r  [NUM_AXES];
  logic [COORD_W-1:0]        pos_in   [NUM_AXES];
  logic [COORD_W:0]          diff     [NUM_AXES];
  logic [COORD_W-1:0]        off_nxt  [NUM_AXES];
  logic [COORD_W-1:0]        off_r    [NUM_AXES];
  in_item_t                  pt_r;
  logic [COORD_W-1:0]        mul_a;
  logic [COORD_W-1:0]        mul_b;
  logic [PROD_W-1:0]         prod_r;
  logic [WHOLE_W-1:0]        whole;
  logic [AXIS_W-1:0]         cell_sat;
  logic [AXIS_W-1:0]         cell_x_r;
  logic [AXIS_W-1:0]         cell_y_r;
  logic [AXIS_W-1:0]         cell_z_r;
  logic [CELL_W-1:0]         cell_idx_r;
  logic [CELL_W-1:0]         clr_addr_r;
  logic [CELL_W-1:0]         ram_addr;
  logic                      ram_wr;
  logic                      ram_rd;
  logic                      out_valid_r;
  out_item_t                 out_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        origin_r[a] <= '0;
        scale_r[a]  <= SCALE_RESET;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X: origin_r[0] <= cfg_wdata;
        REG_ORIGIN_Y: origin_r[1] <= cfg_wdata;
        REG_ORIGIN_Z: origin_r[2] <= cfg_wdata;
        REG_SCALE_X:  scale_r[0]  <= cfg_wdata;
        REG_SCALE_Y:  scale_r[1]  <= cfg_wdata;
        REG_SCALE_Z:  scale_r[2]  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Offset from the origin; zero or negative offsets collapse to zero.
  always_comb begin
    pos_in[0] = in_data.pos_x;
    pos_in[1] = in_data.pos_y;
    pos_in[2] = in_data.pos_z;
    for (int a = 0; a < NUM_AXES; a++) begin
      diff[a] = {pos_in[a][COORD_W-1], pos_in[a]} - {origin_r[a][COORD_W-1], origin_r[a]};
      off_nxt[a] = (!diff[a][COORD_W] && (diff[a] != '0)) ? diff[a][COORD_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load_pt) begin
      pt_r <= in_data;
      for (int a = 0; a < NUM_AXES; a++) begin
        off_r[a] <= off_nxt[a];
      end
    end
  end

  // Shared multiplier, one axis per step.
  always_comb begin
    case (cmd_i.axis)
      AXIS_X: begin
        mul_a = off_r[0];
        mul_b = scale_r[0];
      end
      AXIS_Y: begin
        mul_a = off_r[1];
        mul_b = scale_r[1];
      end
      default: begin
        mul_a = off_r[2];
        mul_b = scale_r[2];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd_i.mul_en) begin
      prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
  end

  // Floor and saturate the product to a cell number.
  assign whole    = prod_r[PROD_W-1:FRAC_BITS];
  assign cell_sat = (whole > WHOLE_MAX) ? CELL_MAX : whole[AXIS_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd_i.sat_en) begin
      case (cmd_i.axis)
        AXIS_X:  cell_x_r <= cell_sat;
        AXIS_Y:  cell_y_r <= cell_sat;
        default: cell_z_r <= cell_sat;
      endcase
    end
    if (cmd_i.index_en) begin
      cell_idx_r <= CELL_W'(cell_x_r) + CELL_W'(cell_y_r) * ROW_STRIDE
                    + CELL_W'(cell_z_r) * PLANE_STRIDE;
    end
  end

  // Clear sweep address.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd_i.clr_start) begin
      clr_addr_r <= '0;
    end else if (cmd_i.clearing) begin
      clr_addr_r <= clr_addr_r + CELL_W'(1);
    end
  end

  assign ram_addr = cmd_i.clearing ? clr_addr_r : cell_idx_r;
  assign ram_wr   = cmd_i.clearing | cmd_i.mark;

  vgs_ram #(
    .WIDTH (1),
    .DEPTH (CELLS)
  ) u_occ_ram (
    .clk     (clk),
    .addr    (ram_addr),
    .wr_en   (ram_wr),
    .wr_data (cmd_i.mark),
    .rd_data (ram_rd)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.emit) begin
      out_r.kept_x     <= pt_r.pos_x;
      out_r.kept_y     <= pt_r.pos_y;
      out_r.kept_z     <= pt_r.pos_z;
      out_r.cell_index <= IDX_OUT_W'(cell_idx_r);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data       = out_r;
  assign sts_o.clr_last = (clr_addr_r == LAST_CELL);
  assign sts_o.occ      = ram_rd;
  assign sts_o.out_free = !out_valid_r || out_ready;

  // An emitted beat carries the index of the cell that was just checked.
  a_emit_index: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.emit |=> out_r.cell_index == IDX_OUT_W'(cell_idx_r))
    else $error("emitted cell index differs from the checked cell");

endmodule

FILE: design/vgs_ctrl.sv
// Controller of the voxel grid subsampler: sequences the clear sweep and the
// per-point steps of the datapath. Depends on vgs_pkg.
module vgs_ctrl import vgs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_clear,
  output logic    in_ready,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_SAT,
    S_INDEX,
    S_READ,
    S_CHECK,
    S_HOLD
  } state_t;

  state_t                state_r;
  state_t                state_nxt;
  logic [AXIS_SEL_W-1:0] axis_r;
  logic [AXIS_SEL_W-1:0] axis_nxt;

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    in_ready  = 1'b0;
    cmd_o     = '0;
    cmd_o.axis = axis_r;
    case (state_r)
      S_CLEAR: begin
        cmd_o.clearing = 1'b1;
        if (sts_i.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_clear == CMD_CLEAR) begin
            cmd_o.clr_start = 1'b1;
            state_nxt = S_CLEAR;
          end else begin
            cmd_o.load_pt = 1'b1;
            axis_nxt  = AXIS_X;
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_nxt = S_SAT;
      end
      S_SAT: begin
        cmd_o.sat_en = 1'b1;
        if (axis_r == AXIS_Z) begin
          state_nxt = S_INDEX;
        end else begin
          axis_nxt  = axis_r + AXIS_SEL_W'(1);
          state_nxt = S_MUL;
        end
      end
      S_INDEX: begin
        cmd_o.index_en = 1'b1;
        state_nxt = S_READ;
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.occ) begin
          state_nxt = S_IDLE;
        end else begin
          cmd_o.mark = 1'b1;
          if (sts_i.out_free) begin
            cmd_o.emit = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      axis_r  <= AXIS_X;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
    end
  end

  // A beat is never loaded over one that is still waiting downstream.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.emit |-> sts_i.out_free)
    else $error("result loaded while output register is occupied");

  // A point walks all three axes and reaches the occupancy check on schedule.
  a_point_schedule: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_clear == CMD_POINT)) |=> ##8 (state_r == S_CHECK))
    else $error("point did not reach the occupancy check on schedule");

  // The store is only marked after a read that found the cell empty.
  a_mark_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.mark |-> ($past(state_r) == S_READ) && !sts_i.occ)
    else $error("occupancy store marked outside a fresh-cell check");

endmodule

FILE: design/voxel_grid_first_point_subsampler.sv
// A point beat is taken only while idle, so the next beat waits until the last is done:
// the single shared 32x32 multiplier steps through the three axes, then the occupancy
// RAM does a read and, for an empty cell, a write, and the point is sent out (held back
// while the output register is full). A clear beat sweeps every cell of the store before
// the next beat is taken. Reset (synchronous, rst_n low) loads register defaults, then
// runs the same clearing sweep with in_ready low; configuration writes are taken during it.
module voxel_grid_first_point_subsampler import vgs_pkg::*; #(
  parameter int GRID = GRID_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data
);

  // The controller owns sequencing only: it decides when a beat is taken,
  // which axis the multiplier works on, and when the store is read, marked,
  // or swept clear. Everything holding data lives in the datapath.
  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  vgs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_clear (in_data.command),
    .in_ready (in_ready),
    .sts_i    (dp_sts),
    .cmd_o    (dp_cmd)
  );

  // The datapath quantizes each axis against the origin and Q16.16 scale,
  // packs the linear cell index, and keeps one occupancy bit per cell in RAM.
  // Its output register lets a finished result wait downstream while the
  // next beat is already being taken and worked on.
  vgs_datapath #(
    .GRID (GRID)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd_i     (dp_cmd),
    .sts_o     (dp_sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
